FILE: design/i2c_master_bit_engine_defines.svh
// Assertion macros shared by the I2C master bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/i2cm_pkg.sv
package i2cm_pkg;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	localparam logic [3:0] DATA_BITS   = 4'd8;
	localparam logic [9:0] PHASE_RESET = 10'd10;

	typedef struct packed {
		logic [2:0] action;
		logic       sda_in;
		logic       ack_level;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic       rejected;
		logic       done_res;
		logic       ack_seen;
		logic [7:0] read_byte;
		logic       busy_res;
		logic       sda_out;
		logic       scl_out;
	} res_t;

endpackage

FILE: design/i2cm_engine.sv
module i2cm_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  i2cm_pkg::item_t  itm,
	input  logic [9:0]       phase_ticks,
	output i2cm_pkg::res_t   res
);

	i2cm_pkg::cmd_t cmd_q, n_cmd;
	logic [1:0] step_q, n_step;
	logic [3:0] bit_q, n_bit;
	logic [7:0] shift_q, n_shift;
	logic [9:0] cnt_q, n_cnt;
	logic       scl_q, n_scl;
	logic       sda_q, n_sda;
	logic       ack_q, n_ack;
	logic [7:0] recv_q, n_recv;
	logic       ackd_q, n_ackd;
	logic       rej, done;

	always_comb begin
		logic [10:0] cnt_inc;
		logic [9:0]  hold;
		logic        is_cmd;
		logic        fin;
		n_cmd   = cmd_q;
		n_step  = step_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_cnt   = cnt_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_ack   = ack_q;
		n_recv  = recv_q;
		n_ackd  = ackd_q;
		rej     = 1'b0;
		done    = 1'b0;
		fin     = 1'b0;
		cnt_inc = '0;
		hold    = (phase_ticks == 10'd0) ? 10'd1 : phase_ticks;
		is_cmd  = (itm.action >= i2cm_pkg::CMD_START) && (itm.action <= i2cm_pkg::CMD_READ);

		if (cmd_q != i2cm_pkg::CMD_IDLE) begin
			if (is_cmd) begin
				rej = 1'b1;
			end
		end else if (is_cmd) begin
			n_cmd   = i2cm_pkg::cmd_t'(itm.action);
			n_step  = 2'd0;
			n_bit   = 4'd0;
			n_cnt   = 10'd0;
			n_shift = (itm.action == i2cm_pkg::CMD_WRITE) ? itm.data_byte : 8'd0;
			if (itm.action == i2cm_pkg::CMD_READ) begin
				n_ackd = itm.ack_level;
			end
		end

		if (n_cmd != i2cm_pkg::CMD_IDLE) begin
			// A step makes its line change on its first tick only.
			if (n_cnt == 10'd0) begin
				if (n_cmd == i2cm_pkg::CMD_START) begin
					unique case (n_step)
						2'd0: n_sda = 1'b1;
						2'd1: n_scl = 1'b1;
						2'd2: n_sda = 1'b0;
						default: n_scl = 1'b0;
					endcase
				end else if (n_cmd == i2cm_pkg::CMD_STOP) begin
					unique case (n_step)
						2'd0: n_scl = 1'b0;
						2'd1: n_sda = 1'b0;
						2'd2: n_scl = 1'b1;
						default: n_sda = 1'b1;
					endcase
				end else if (n_step == 2'd0 || n_step == 2'd3) begin
					n_scl = 1'b0;
				end else if (n_step == 2'd2) begin
					n_scl = 1'b1;
				end else if (n_bit < i2cm_pkg::DATA_BITS) begin
					n_sda = (n_cmd == i2cm_pkg::CMD_WRITE) ?
						n_shift[3'd7 - n_bit[2:0]] : 1'b1;
				end else begin
					n_sda = (n_cmd == i2cm_pkg::CMD_WRITE) ? 1'b1 : n_ackd;
				end
			end

			cnt_inc = {1'b0, n_cnt} + 11'd1;
			if (cnt_inc >= {1'b0, hold}) begin
				n_cnt = 10'd0;
				if (n_cmd == i2cm_pkg::CMD_START || n_cmd == i2cm_pkg::CMD_STOP) begin
					if (n_step == 2'd3) begin
						fin = 1'b1;
					end else begin
						n_step = n_step + 2'd1;
					end
				end else if (n_bit < i2cm_pkg::DATA_BITS) begin
					if (n_step >= 2'd2) begin
						if (n_cmd == i2cm_pkg::CMD_READ) begin
							n_shift = {n_shift[6:0], itm.sda_in};
						end
						n_bit  = n_bit + 4'd1;
						n_step = 2'd0;
					end else begin
						n_step = n_step + 2'd1;
					end
				end else begin
					if (n_step == 2'd2 && n_cmd == i2cm_pkg::CMD_WRITE) begin
						n_ack = itm.sda_in;
					end
					if (n_step == 2'd3) begin
						if (n_cmd == i2cm_pkg::CMD_READ) begin
							n_recv = n_shift;
						end
						fin = 1'b1;
					end else begin
						n_step = n_step + 2'd1;
					end
				end
			end else begin
				n_cnt = cnt_inc[9:0];
			end

			if (fin) begin
				n_cmd  = i2cm_pkg::CMD_IDLE;
				n_step = 2'd0;
				n_bit  = 4'd0;
				done   = 1'b1;
			end
		end

		res.scl_out   = n_scl;
		res.sda_out   = n_sda;
		res.busy_res  = (n_cmd != i2cm_pkg::CMD_IDLE);
		res.read_byte = n_recv;
		res.ack_seen  = n_ack;
		res.done_res  = done;
		res.rejected  = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cm_pkg::CMD_IDLE;
			step_q  <= 2'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			cnt_q   <= 10'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b1;
			recv_q  <= 8'd0;
			ackd_q  <= 1'b0;
		end else if (en) begin
			cmd_q   <= n_cmd;
			step_q  <= n_step;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			cnt_q   <= n_cnt;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			ack_q   <= n_ack;
			recv_q  <= n_recv;
			ackd_q  <= n_ackd;
		end
	end

endmodule

FILE: design/i2c_master_bit_engine.sv
// I2C master bit engine. Every input transaction is one timing tick and may carry a command
// (start, stop, write byte with ack sampling, read byte with a chosen ack level); every tick
// yields exactly one result transaction with the open-drain drive levels, busy, the last read
// byte, the last write ack, a done pulse and a rejected flag. One tick is taken per clock
// cycle: the tick is registered on entry, the bit sequencer updates its state and forms the
// result in one pass, and the result register holds it for the output side; throughput is one
// transaction per cycle while the output side keeps tready high.
// Each SCL or SDA change is held for phase_ticks ticks (a value of zero acts as one).
`include "i2c_master_bit_engine_defines.svh"

module i2c_master_bit_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [9:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// data_byte [7:0], ack_level [8], sda_in [9], zero [15:10]
	input  logic [15:0] s_axis_tdata,
	// action [2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// scl_out [0], sda_out [1], busy_res [2], read_byte [10:3], ack_seen [11],
	// done_res [12], rejected [13], zero [15:14]
	output logic [15:0] m_axis_tdata
);

	logic [9:0]      phase_ticks_q;
	i2cm_pkg::item_t item_s1;
	logic            valid_s1;
	i2cm_pkg::res_t  res_c;
	i2cm_pkg::res_t  res_q;
	logic            out_valid_q;
	logic            out_free;
	logic            advance;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cm_pkg::PHASE_RESET;
		end else if (cfg_wr_en) begin
			phase_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= {s_axis_tuser, s_axis_tdata[9], s_axis_tdata[8], s_axis_tdata[7:0]};
		end
	end

	i2cm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.itm         (item_s1),
		.phase_ticks (phase_ticks_q),
		.res         (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q};

	`I2CM_ASSERT_NOW(a_ready_follows_out, m_axis_tready, s_axis_tready,
		"Input stalled although the output side is ready.")
	`I2CM_ASSERT_NEXT(a_advance_gives_result, advance, m_axis_tvalid,
		"A processed tick produced no result transaction.")
	`I2CM_ASSERT_NOW(a_done_not_busy, m_axis_tvalid, !(res_q.done_res && res_q.busy_res),
		"Done reported while still busy.")

endmodule
